FILE: hw/rtl/console_line_editor_echo_macros.svh
// assertion macros shared by the console line editor modules
// no dependencies; included by the files that carry assertions
`ifndef CONSOLE_LINE_EDITOR_ECHO_MACROS_SVH
`define CONSOLE_LINE_EDITOR_ECHO_MACROS_SVH

// condition holds at every edge out of reset
`define CLE_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// same-cycle implication
`define CLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/cle_pkg.sv
// constants, types and helpers for the console line editor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    localparam int LINE_DEPTH = 128;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int WPOS_W     = $clog2(LINE_DEPTH + 1);

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 8;
    localparam int KIND_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_RX      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BUSY  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SP = 8'd32;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // what one accepted item turns into on the output side
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ECHO,
        OP_CRLF,
        OP_CRLF_RDY,
        OP_BS,
        OP_READ,
        OP_BUSY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_plan;

    function automatic logic [1:0] op_count(input t_op op);
        logic [1:0] n;
        case (op)
            OP_ECHO:     n = 2'd1;
            OP_CRLF:     n = 2'd2;
            OP_CRLF_RDY: n = 2'd3;
            OP_BS:       n = 2'd3;
            OP_READ:     n = 2'd1;
            OP_BUSY:     n = 2'd1;
            default:     n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [WPOS_W-1:0] w);
        logic [LEN_W-1:0] r;
        if (32'(w) > 32'(LEN_MAX)) begin
            r = LEN_MAX;
        end else begin
            r = LEN_W'(w);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/console_line_editor_echo.sv
// top level of the console line editor with echo
// holds the report-enable register and joins cle_line and cle_seq; uses cle_pkg
//
// channel   dir  valid/ready                       tuser     tdata (low bit up)
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   cmd       rx_byte, read_index, pad
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   kind      out_byte, line_length
// cfg       in   i_cfg_wr_en                       -         line_reports_enabled
//
// an item is decoded and applied to the line state in its accept cycle
// results leave one per cycle: 1 result for echo/read/busy, 2 for CR LF
// without a report, 3 for CR LF with line ready or for backspace
// the output register stalls on i_m_axis_tready; a new item enters as the last
// result of the previous one moves into the output register
// synchronous active-low reset clears the write position, held flag and
// sequencer; the line store has no reset
`timescale 1ns / 1ps
`default_nettype none

module console_line_editor_echo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [cle_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // rx_byte, read_index, zero
    input  wire logic [cle_pkg::CMD_W-1:0]     i_s_axis_tuser,  // cmd
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [cle_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // out_byte, line_length
    output logic [cle_pkg::KIND_W-1:0]         o_m_axis_tuser,  // kind
    output logic                               o_m_axis_tlast,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data
);
    import cle_pkg::*;

    logic              r_reports_en;
    logic              seq_free;
    logic              accept;
    t_plan             plan;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reports_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_reports_en <= i_cfg_wr_data;
        end
    end

    assign o_s_axis_tready = seq_free;
    assign accept          = i_s_axis_tvalid && seq_free;

    cle_line u_line (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_cmd        (i_s_axis_tuser),
        .i_rx_byte    (i_s_axis_tdata[BYTE_W-1:0]),
        .i_read_index (i_s_axis_tdata[BYTE_W+IDX_W-1:BYTE_W]),
        .i_reports_en (r_reports_en),
        .o_plan       (plan),
        .o_rd_data    (rd_data)
    );

    cle_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_plan    (plan),
        .i_rd_data (rd_data),
        .o_free    (seq_free),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_data    (out_byte),
        .o_len     (out_len),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_len, out_byte};

endmodule

`default_nettype wire

FILE: hw/rtl/cle_line.sv
// line state: write position, held flag and the line store
// decodes each accepted item into an output plan; uses cle_pkg
`timescale 1ns / 1ps
`default_nettype none

module cle_line (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic [cle_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [cle_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic [cle_pkg::IDX_W-1:0]  i_read_index,
    input  wire logic                       i_reports_en,
    output cle_pkg::t_plan                  o_plan,
    output logic [cle_pkg::BYTE_W-1:0]      o_rd_data
);
    import cle_pkg::*;

    logic [BYTE_W-1:0] r_mem [LINE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic [WPOS_W-1:0] r_wpos;
    logic [WPOS_W-1:0] n_wpos;
    logic              r_pending;
    logic              n_pending;
    logic              wr_en;
    logic              is_eol;
    logic              rd_in_range;

    assign is_eol      = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign rd_in_range = 32'(i_read_index) < 32'(LINE_DEPTH);

    always_comb begin
        n_wpos      = r_wpos;
        n_pending   = r_pending;
        wr_en       = 1'b0;
        o_plan.op   = OP_NONE;
        o_plan.data = i_rx_byte;
        o_plan.len  = sat_len(r_wpos);
        case (i_cmd)
            CMD_READ: begin
                o_plan.op = OP_READ;
            end
            CMD_RELEASE: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_wpos    = '0;
                end
            end
            CMD_RX: begin
                if (r_pending) begin
                    o_plan.op = OP_BUSY;
                end else if (is_eol) begin
                    if (i_reports_en) begin
                        o_plan.op = OP_CRLF_RDY;
                        n_pending = 1'b1;
                    end else begin
                        o_plan.op = OP_CRLF;
                        n_wpos    = '0;
                    end
                end else if (i_rx_byte == CH_BS) begin
                    if (r_wpos != '0) begin
                        o_plan.op = OP_BS;
                        n_wpos    = r_wpos - 1'b1;
                    end
                end else if (32'(r_wpos) < 32'(LINE_DEPTH)) begin
                    o_plan.op = OP_ECHO;
                    wr_en     = 1'b1;
                    n_wpos    = r_wpos + 1'b1;
                end
            end
            default: begin
                o_plan.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_pending <= 1'b0;
        end else if (i_load) begin
            r_wpos    <= n_wpos;
            r_pending <= n_pending;
        end
    end

    // line store, no reset; read data held until the next read item
    always_ff @(posedge i_clk) begin
        if (i_load && wr_en) begin
            r_mem[r_wpos[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_load && (i_cmd == CMD_READ)) begin
            r_rd_data <= r_mem[ADDR_W'(i_read_index)];
            r_rd_ok   <= rd_in_range;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/cle_seq.sv
// result sequencer: holds one plan and steps it out through the output register
// uses cle_pkg and the shared assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "console_line_editor_echo_macros.svh"

module cle_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire cle_pkg::t_plan             i_plan,
    input  wire logic [cle_pkg::BYTE_W-1:0] i_rd_data,
    output logic                            o_free,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [cle_pkg::KIND_W-1:0]      o_kind,
    output logic [cle_pkg::BYTE_W-1:0]      o_data,
    output logic [cle_pkg::LEN_W-1:0]       o_len,
    output logic                            o_last
);
    import cle_pkg::*;

    t_plan             r_plan;
    logic [1:0]        r_rem;
    logic [1:0]        r_step;
    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;
    logic [KIND_W-1:0] n_kind;
    logic [BYTE_W-1:0] n_data;
    logic [LEN_W-1:0]  n_len;
    logic              out_adv;
    logic              emit;

    assign out_adv = !r_valid || i_ready;
    assign emit    = out_adv && (r_rem != 2'd0);
    assign o_free  = (r_rem == 2'd0) || ((r_rem == 2'd1) && out_adv);

    always_comb begin
        n_kind = KIND_ECHO;
        n_data = '0;
        n_len  = '0;
        case (r_plan.op)
            OP_ECHO: begin
                n_data = r_plan.data;
            end
            OP_CRLF, OP_CRLF_RDY: begin
                if (r_step == 2'd0) begin
                    n_data = CH_CR;
                end else if (r_step == 2'd1) begin
                    n_data = CH_LF;
                end else begin
                    n_kind = KIND_READY;
                    n_len  = r_plan.len;
                end
            end
            OP_BS: begin
                n_data = (r_step == 2'd1) ? CH_SP : CH_BS;
            end
            OP_READ: begin
                n_kind = KIND_READ;
                n_data = i_rd_data;
            end
            OP_BUSY: begin
                n_kind = KIND_BUSY;
            end
            default: begin
                n_kind = KIND_ECHO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= 2'd0;
            r_step  <= 2'd0;
        end else begin
            if (out_adv) begin
                r_valid <= (r_rem != 2'd0);
            end
            if (emit) begin
                r_rem  <= r_rem - 2'd1;
                r_step <= r_step + 2'd1;
            end
            if (i_load) begin
                r_rem  <= op_count(i_plan.op);
                r_step <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
        end
        if (emit) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_len  <= n_len;
            r_last <= (r_rem == 2'd1);
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;
    assign o_len   = r_len;
    assign o_last  = r_last;

    `CLE_ASSERT_IMP(a_rem_le_count, i_clk, i_rst_n, r_rem != 2'd0, r_rem <= op_count(r_plan.op))
    `CLE_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_load, o_free)
    `CLE_ASSERT_NEXT(a_rem_steps, i_clk, i_rst_n, emit && !i_load, r_rem == $past(r_rem) - 2'd1)
    `CLE_ASSERT_NEXT(a_final_marked, i_clk, i_rst_n, emit && (r_rem == 2'd1), r_valid && r_last)

endmodule

`default_nettype wire
